// ----- rtl/core/xsb_pkg.sv -----
// Shared types and constants for the xorshift128 bounded random unit.
package xsb_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned CntW  = $clog2(WordW);

	localparam logic [WordW-1:0] SeedA = 32'd123456789;
	localparam logic [WordW-1:0] SeedB = 32'd362436069;
	localparam logic [WordW-1:0] SeedC = 32'd521288629;
	localparam logic [WordW-1:0] SeedD = 32'd88675123;

	localparam int unsigned ShA = 11;
	localparam int unsigned ShD = 19;
	localparam int unsigned ShT = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HOLD
	} xsb_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/core/xsb_gen.sv -----
// xorshift128 state words and one-step update.
module xsb_gen
	import xsb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	output logic [WordW-1:0] nxt_word
);

	logic [WordW-1:0] a_q, b_q, c_q, d_q;
	logic [WordW-1:0] t;

	assign t        = a_q ^ (a_q << ShA);
	assign nxt_word = (d_q ^ (d_q >> ShD)) ^ (t ^ (t >> ShT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= SeedA;
			b_q <= SeedB;
			c_q <= SeedC;
			d_q <= SeedD;
		end else if (adv) begin
			a_q <= b_q;
			b_q <= c_q;
			c_q <= d_q;
			d_q <= nxt_word;
		end
	end

endmodule

// ----- rtl/core/xsb_div.sv -----
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module xsb_div
	import xsb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WordW-1:0] dividend,
	input  logic [WordW-1:0] divisor,
	output div_stat_t        stat,
	output logic [WordW-1:0] rem
);

	logic [WordW-1:0] dvd_q;
	logic [WordW-1:0] dvs_q;
	logic [WordW-1:0] rem_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WordW:0]   trial;
	logic [WordW:0]   diff;

	assign trial = {rem_q, dvd_q[WordW-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(WordW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= diff[WordW] ? trial[WordW-1:0] : diff[WordW-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;

endmodule

// ----- rtl/core/xorshift128_bounded_random_unit.sv -----
// Top level of the xorshift128 bounded random unit.
// Each request advances the xorshift128 state once and returns the new word, raw
// (tuser 0) or reduced modulo the bound in tdata (tuser 1). A zero bound
// on a modulo request returns 0 with the error flag set. Raw and zero-bound
// requests are registered at acceptance; a modulo request waits for the
// bit-serial remainder unit, which retires one dividend bit per cycle. The next
// request is taken as soon as the result has moved to the output register.
module xorshift128_bounded_random_unit
	import xsb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [WordW-1:0] s_tdata,  // [31:0] bound
	input  logic             s_tuser,  // [0] func
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [WordW-1:0] m_tdata,  // [31:0] value
	output logic             m_tuser   // [0] bad_bound
);

	xsb_state_t       state_q, state_nxt;
	logic             accept;
	logic             zero_bnd;
	logic             div_start;
	logic             load_out;
	logic [WordW-1:0] word;
	logic [WordW-1:0] rem;
	div_stat_t        stat;
	logic [WordW-1:0] res_q;
	logic             rbad_q;
	logic [WordW-1:0] val_q;
	logic             bad_q;
	logic             ovalid_q;

	assign zero_bnd = (s_tdata == '0);
	assign accept   = s_tvalid && s_tready;

	xsb_gen u_gen (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (accept),
		.nxt_word (word)
	);

	xsb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (word),
		.divisor  (s_tdata),
		.stat     (stat),
		.rem      (rem)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = (s_tuser && !zero_bnd) ? ST_DIV : ST_HOLD;
				end
			end
			ST_DIV: begin
				if (stat.done) begin
					state_nxt = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (!ovalid_q || m_tready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		div_start = (state_q == ST_IDLE) && s_tvalid && s_tuser && !zero_bnd;
		load_out  = (state_q == ST_HOLD) && (!ovalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q  <= s_tuser ? '0 : word;
			rbad_q <= s_tuser && zero_bnd;
		end else if (state_q == ST_DIV && stat.done) begin
			res_q <= rem;
		end
		if (load_out) begin
			val_q <= res_q;
			bad_q <= rbad_q;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = val_q;
	assign m_tuser  = bad_q;

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("request accepted while previous one still in progress");

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("bad bound result carries a nonzero value");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.busy || stat.done) |-> (state_q == ST_DIV))
		else $error("remainder unit active outside its state");

	a_start_to_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (stat.busy && state_q == ST_DIV))
		else $error("remainder unit did not start");

endmodule

// ----- sim/tb_xorshift128_bounded_random_unit.sv -----
// Self-checking testbench for the xorshift128 bounded random unit.
`timescale 1ns / 1ps

module tb_xorshift128_bounded_random_unit;
	import xsb_pkg::*;

	localparam bit FUNC_RAW = 1'b0;
	localparam bit FUNC_MOD = 1'b1;
	localparam int unsigned RAND_REQS = 1940;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [WordW-1:0] value;
		logic             bad;
	} rng_result_t;

	typedef struct packed {
		logic             func;
		logic [WordW-1:0] bound;
		logic             known;
		logic [WordW-1:0] value;
		logic             bad;
	} dir_row_t;

	localparam int unsigned DIR_ROWS = 16;
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		'{FUNC_RAW, 32'h0000_0000, 1'b1, 32'd3701687786, 1'b0},
		'{FUNC_RAW, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
		'{FUNC_MOD, 32'h0000_0000, 1'b1, 32'd0, 1'b1},
		'{FUNC_MOD, 32'h0000_0001, 1'b1, 32'd0, 1'b0},
		'{FUNC_MOD, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
		'{FUNC_MOD, 32'h8000_0000, 1'b0, 32'd0, 1'b0},
		'{FUNC_MOD, 32'h0000_0002, 1'b0, 32'd0, 1'b0},
		'{FUNC_MOD, 32'h0000_0003, 1'b0, 32'd0, 1'b0},
		'{FUNC_RAW, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
		'{FUNC_MOD, 32'h0000_0000, 1'b1, 32'd0, 1'b1},
		'{FUNC_MOD, 32'hFFFF_FFFE, 1'b0, 32'd0, 1'b0},
		'{FUNC_MOD, 32'h7FFF_FFFF, 1'b0, 32'd0, 1'b0},
		'{FUNC_MOD, 32'h0001_0001, 1'b0, 32'd0, 1'b0},
		'{FUNC_RAW, 32'hAAAA_AAAA, 1'b0, 32'd0, 1'b0},
		'{FUNC_MOD, 32'h5555_5555, 1'b0, 32'd0, 1'b0},
		'{FUNC_MOD, 32'h0000_0001, 1'b1, 32'd0, 1'b0}
	};

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [WordW-1:0] s_tdata;  // [31:0] bound
	logic             s_tuser;  // [0] func
	logic             m_tvalid;
	logic             m_tready;
	logic [WordW-1:0] m_tdata;  // [31:0] value
	logic             m_tuser;  // [0] bad_bound

	logic [WordW-1:0] st_a, st_b, st_c, st_d;
	rng_result_t      pending_q[$];
	int unsigned      cycle_cnt = 0;
	int unsigned      err_cnt = 0;
	int unsigned      req_cnt = 0;
	int unsigned      raw_cnt = 0;
	int unsigned      mod_cnt = 0;
	int unsigned      zero_cnt = 0;
	int unsigned      chk_cnt = 0;

	xorshift128_bounded_random_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
			pending_q.size());
		$display("tb_xorshift128_bounded_random_unit: FAIL");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [WordW-1:0] pick_bound();
		logic [WordW-1:0] w;
		w = $urandom;
		case ($urandom_range(0, 15))
			0: return '0;
			1: return 32'd1;
			2: return $urandom_range(2, 16);
			3: return 32'd1 << $urandom_range(0, 31);
			4: return 32'hFFFF_FFFF - $urandom_range(0, 15);
			5: return $urandom_range(2, 1000);
			6, 7: return w >> $urandom_range(0, 31);
			default: return w;
		endcase
	endfunction

	task automatic predict_word(input logic func, input logic [WordW-1:0] bound,
			output rng_result_t res);
		logic [WordW-1:0] t;
		t = st_a ^ (st_a << ShA);
		st_a = st_b;
		st_b = st_c;
		st_c = st_d;
		st_d = (st_d ^ (st_d >> ShD)) ^ (t ^ (t >> ShT));
		res.bad = 1'b0;
		res.value = st_d;
		if (func == FUNC_MOD) begin
			if (bound == '0) begin
				res.value = '0;
				res.bad = 1'b1;
			end else begin
				res.value = st_d % bound;
			end
		end
	endtask

	task automatic send_request(input logic func, input logic [WordW-1:0] bound,
			input logic known, input rng_result_t typed, input bit calm);
		int unsigned gap;
		rng_result_t res;
		gap = calm ? 0 : pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= bound;
		do @(posedge clk); while (!s_tready);
		predict_word(func, bound, res);
		pending_q = {pending_q, (known ? typed : res)};
		req_cnt++;
		if (func == FUNC_RAW) raw_cnt++;
		else if (bound == '0) zero_cnt++;
		else mod_cnt++;
	endtask

	initial begin
		rng_result_t typed;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= FUNC_RAW;
		arst_n <= 1'b0;
		st_a = SeedA;
		st_b = SeedB;
		st_c = SeedC;
		st_d = SeedD;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			typed.value = DIR_TAB[i].value;
			typed.bad = DIR_TAB[i].bad;
			send_request(DIR_TAB[i].func, DIR_TAB[i].bound, DIR_TAB[i].known, typed,
				(i % 4) == 3);
		end

		typed = '0;
		for (int i = 0; i < RAND_REQS; i++) begin
			send_request(($urandom_range(0, 9) < 7) ? FUNC_MOD : FUNC_RAW, pick_bound(),
				1'b0, typed, ((i / 150) % 4) == 3);
		end
		s_tvalid <= 1'b0;

		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests: %0d raw, %0d modulo, %0d zero bound; %0d results checked",
			req_cnt, raw_cnt, mod_cnt, zero_cnt, chk_cnt);
		$display("random gaps and stalls on both sides, with stall-free stretches");
		if (err_cnt == 0) begin
			$display("tb_xorshift128_bounded_random_unit: PASS");
		end else begin
			$display("%0d errors", err_cnt);
			$display("tb_xorshift128_bounded_random_unit: FAIL");
		end
		$finish;
	end

	// result side: check accepted results, then pick the next ready value
	initial begin
		int unsigned stall;
		rng_result_t want;
		stall = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				chk_cnt++;
				if (pending_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected result value=%h bad=%b", m_tdata, m_tuser);
				end else begin
					want = pending_q.pop_front();
					if (m_tdata !== want.value || m_tuser !== want.bad) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("result %0d: expected value=%h bad=%b, got value=%h bad=%b",
								chk_cnt, want.value, want.bad, m_tdata, m_tuser);
					end
				end
			end
			if (stall != 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (((cycle_cnt / 2000) % 4) != 3) stall = pick_gap();
			end
		end
	end

endmodule
